[sv/assert_macros.svh]
// assertion macros shared by the url percent decoder modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// condition that must never be true outside reset
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error(msg);

`endif

[sv/upd_pkg.sv]
// shared types, character codes and hex helper for the url percent decoder
`timescale 1ns / 1ps

package upd_pkg;

    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_SPACE   = 8'h20;

    // byte count of one job, 1 to 3
    typedef logic [1:0] t_cnt;

    // output bytes caused by one input request
    typedef struct packed {
        logic [2:0][7:0] bytes;
        t_cnt            cnt;
        logic            last;
    } t_job;

    // {is_hex, digit value}
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [7:0] t;
        logic       ok;
        t  = 8'h00;
        ok = 1'b0;
        if (c inside {[8'h30:8'h39]}) begin
            t  = c - 8'h30;
            ok = 1'b1;
        end else if (c inside {[8'h41:8'h46]}) begin
            t  = c - 8'h37;
            ok = 1'b1;
        end else if (c inside {[8'h61:8'h66]}) begin
            t  = c - 8'h57;
            ok = 1'b1;
        end
        return {ok, t[3:0]};
    endfunction

endpackage

[sv/upd_front.sv]
// front end: accepts encoded characters, tracks escapes and builds output jobs
`timescale 1ns / 1ps

module upd_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [7:0]    i_byte,
    input  logic          i_last,
    input  logic          i_full,
    output logic          o_ready,
    output logic          o_push,
    output upd_pkg::t_job o_job
);

    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_PCT  = 3'b010,
        PH_DIG  = 3'b100
    } t_phase;

    t_phase     r_phase, n_phase;
    logic [7:0] r_first, n_first;
    logic       accept;
    logic [4:0] cur_hex;
    logic [4:0] first_hex;

    assign o_ready   = !i_full;
    assign accept    = i_valid && o_ready;
    assign cur_hex   = upd_pkg::hex_decode(i_byte);
    assign first_hex = upd_pkg::hex_decode(r_first);

    always_comb begin
        n_phase     = PH_IDLE;
        n_first     = r_first;
        o_job.bytes = '0;
        o_job.cnt   = 2'd0;
        o_job.last  = i_last;
        case (r_phase)
            PH_PCT: begin
                if (cur_hex[4] && !i_last) begin
                    n_first = i_byte;
                    n_phase = PH_DIG;
                end else begin
                    o_job.bytes[0] = upd_pkg::CH_PERCENT;
                    o_job.bytes[1] = i_byte;
                    o_job.cnt      = 2'd2;
                end
            end
            PH_DIG: begin
                if (cur_hex[4]) begin
                    o_job.bytes[0] = {first_hex[3:0], cur_hex[3:0]};
                    o_job.cnt      = 2'd1;
                end else begin
                    o_job.bytes[0] = upd_pkg::CH_PERCENT;
                    o_job.bytes[1] = r_first;
                    o_job.bytes[2] = i_byte;
                    o_job.cnt      = 2'd3;
                end
            end
            default: begin
                if (i_byte == upd_pkg::CH_PERCENT && !i_last) begin
                    n_phase = PH_PCT;
                end else if (i_byte == upd_pkg::CH_PLUS) begin
                    o_job.bytes[0] = upd_pkg::CH_SPACE;
                    o_job.cnt      = 2'd1;
                end else begin
                    o_job.bytes[0] = i_byte;
                    o_job.cnt      = 2'd1;
                end
            end
        endcase
    end

    assign o_push = accept && (o_job.cnt != 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_first <= 8'h00;
        end else if (accept) begin
            r_phase <= n_phase;
            r_first <= n_first;
        end
    end

endmodule

[sv/upd_queue.sv]
// small job queue between front and back end
`timescale 1ns / 1ps
`include "assert_macros.svh"

module upd_queue #(
    parameter int DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  upd_pkg::t_job i_job,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_empty,
    output upd_pkg::t_job o_head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_MAX = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_MAX = CW'(DEPTH);

    upd_pkg::t_job r_mem [DEPTH];
    logic [PW-1:0] r_wr, n_wr;
    logic [PW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_cnt, n_cnt;

    assign o_full  = (r_cnt == CNT_MAX);
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == PTR_MAX) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == PTR_MAX) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    `ASSERT_NEVER(a_no_overflow, i_push && o_full, "push into full job queue")
    `ASSERT_NEVER(a_no_underflow, i_pop && o_empty, "pop from empty job queue")
    `ASSERT_CLK(a_cnt_up, i_push && !i_pop |=> r_cnt == $past(r_cnt) + 1'b1, "queue count slip")

endmodule

[sv/upd_back.sv]
// back end: walks the bytes of the head job onto the output stream
`timescale 1ns / 1ps
`include "assert_macros.svh"

module upd_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_empty,
    input  upd_pkg::t_job i_head,
    input  logic          i_ready,
    output logic          o_pop,
    output logic          o_valid,
    output logic [7:0]    o_byte,
    output logic          o_run_last,
    output logic          o_text_end
);

    logic [1:0] r_idx, n_idx;
    logic       take;

    assign o_valid    = !i_empty;
    assign o_run_last = (r_idx == i_head.cnt - 2'd1);
    assign o_text_end = o_run_last && i_head.last;
    assign take       = o_valid && i_ready;
    assign o_pop      = take && o_run_last;

    always_comb begin
        case (r_idx)
            2'd1:    o_byte = i_head.bytes[1];
            2'd2:    o_byte = i_head.bytes[2];
            default: o_byte = i_head.bytes[0];
        endcase
    end

    always_comb begin
        n_idx = r_idx;
        if (take) begin
            n_idx = o_run_last ? 2'd0 : r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= 2'd0;
        end else begin
            r_idx <= n_idx;
        end
    end

    `ASSERT_CLK(a_job_nonempty, !i_empty |-> i_head.cnt != 2'd0, "empty job in queue")
    `ASSERT_CLK(a_idx_in_job, !i_empty |-> r_idx < i_head.cnt, "byte index past job end")

endmodule

[sv/url_percent_decoder.sv]
// top level of the url percent decoder
`timescale 1ns / 1ps
// url percent decoder
// input stream: one encoded character per request, tlast on the final
// character of the text. output stream: one decoded byte per request,
// tlast on the last byte caused by one input character, tuser on the
// final byte of the decoded text.
// '+' becomes a space, '%' with two hex digits becomes one byte, bad
// escapes and escapes cut off by the end of the text pass through raw.
// a character that opens or continues an escape yields no output.
// throughput: one input character per cycle while the job queue is not
// full; the back end sends one byte per cycle while m_axis_tready is high,
// so a bad escape (two or three bytes) holds it while the job queue
// absorbs further input. a byte shows on the output in the cycle after
// its character is taken, when the queue was empty.
// s_axis_tready depends only on the queue fill, never on m_axis_tready;
// a stalled receiver fills the queue and then backs up the sender.
// reset clears escape state, queue and byte index; no stream is pending.

module url_percent_decoder #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
    input  logic       s_axis_tlast,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic       m_axis_tlast,
    output logic       m_axis_tuser    // [0] text_end
);

    upd_pkg::t_job front_job;
    upd_pkg::t_job head_job;
    logic          push;
    logic          pop;
    logic          full;
    logic          empty;

    // classify characters and track the escape phase
    upd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .i_byte  (s_axis_tdata),
        .i_last  (s_axis_tlast),
        .i_full  (full),
        .o_ready (s_axis_tready),
        .o_push  (push),
        .o_job   (front_job)
    );

    // jobs waiting for the output side
    upd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_head  (head_job)
    );

    // serialize each job onto the output stream
    upd_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_empty    (empty),
        .i_head     (head_job),
        .i_ready    (m_axis_tready),
        .o_pop      (pop),
        .o_valid    (m_axis_tvalid),
        .o_byte     (m_axis_tdata),
        .o_run_last (m_axis_tlast),
        .o_text_end (m_axis_tuser)
    );

endmodule

[tb/tb.sv]
// self-checking testbench for the url percent decoder stream block
`timescale 1ns / 1ps

module tb;

    // no-handshake cycles before the run is declared hung
    localparam int STALL_LIMIT = 2000;
    // length of the long receiver hold-off that backs up the input side
    localparam int HOLD_CYCLES = 60;
    // settle time after the last expected byte
    localparam int DRAIN_CYCLES = 8;
    localparam int RANDOM_ITEMS = 200;
    localparam int MAX_REPORTS = 50;

    // escape tracking of the predictor
    typedef enum logic [1:0] {
        ESC_NONE  = 2'd0,
        ESC_PCT   = 2'd1,
        ESC_DIGIT = 2'd2
    } t_esc_phase;

    // one encoded character with its end-of-text flag
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_enc_char;

    // one decoded byte as the output stream should carry it
    typedef struct packed {
        logic [7:0] data;
        logic       run_last;
        logic       text_end;
    } t_dec_byte;

    logic       i_clk;
    logic       i_rst_n = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = 8'h00;   // [7:0] in_byte
    logic       s_axis_tlast = 1'b0;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;           // [7:0] out_byte
    logic       m_axis_tlast;
    logic       m_axis_tuser;           // [0] text_end

    url_percent_decoder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    // encoded characters still to be offered, filled once at time zero
    t_enc_char  char_q[$];
    // characters of the text under construction
    logic [7:0] text_buf[$];
    // decoded bytes predicted but not yet seen on the output
    t_dec_byte  decoded_q[$];

    t_enc_char  cur_char;
    logic       cur_busy = 1'b0;
    logic       in_fire = 1'b0;
    logic       out_fire = 1'b0;
    int         n_total = 0;
    int         n_taken = 0;
    int         err_cnt = 0;
    int         quiet_cycles = 0;
    int         hold_left = 0;
    logic       hold_done = 1'b0;

    // predictor state
    t_esc_phase esc_phase = ESC_NONE;
    logic [7:0] first_digit = 8'h00;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // hex digit value 0..15, or 16 when the character is not a hex digit
    function automatic int hex_nibble(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;        // 0-9
        if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;   // A-F
        if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;   // a-f
        return 16;
    endfunction

    // random hex digit character, either case for letters
    function automatic logic [7:0] rand_hex();
        int v;
        v = $urandom_range(0, 15);
        if (v < 10) return 8'h30 + 8'(v);
        return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(v - 10);
    endfunction

    // idle percentage per side: first phase sender 31 / receiver 53,
    // second phase the other way round, last phase no idling at all
    function automatic int idle_pct(input logic rx_side);
        int ph;
        ph = (n_total > 0) ? (n_taken * 3) / n_total : 0;
        if (ph == 0) return rx_side ? 53 : 31;
        if (ph == 1) return rx_side ? 31 : 53;
        return 0;
    endfunction

    task automatic put_str(input string s);
        for (int i = 0; i < s.len(); i++) begin
            text_buf.insert(text_buf.size(), s[i]);
        end
    endtask

    // move the text under construction into the send queue, tlast on its final character
    task automatic close_text();
        for (int i = 0; i < text_buf.size(); i++) begin
            char_q.insert(char_q.size(),
                          '{ch: text_buf[i], last: (i == text_buf.size() - 1)});
        end
        text_buf.delete();
    endtask

    // work out the decoded bytes caused by one accepted character
    task automatic decode_char(input logic [7:0] ch, input logic last);
        logic [7:0] bytes[$];
        int         d;
        int         hi;
        d = hex_nibble(ch);
        case (esc_phase)
            ESC_PCT: begin
                if (d < 16 && !last) begin
                    // first digit of the escape, nothing to emit yet
                    first_digit = ch;
                    esc_phase = ESC_DIGIT;
                    return;
                end
                // bad first digit or text cut off: both pass through raw
                bytes.insert(bytes.size(), upd_pkg::CH_PERCENT);
                bytes.insert(bytes.size(), ch);
            end
            ESC_DIGIT: begin
                if (d < 16) begin
                    hi = hex_nibble(first_digit);
                    bytes.insert(bytes.size(), 8'(hi * 16 + d));
                end else begin
                    bytes.insert(bytes.size(), upd_pkg::CH_PERCENT);
                    bytes.insert(bytes.size(), first_digit);
                    bytes.insert(bytes.size(), ch);
                end
            end
            default: begin
                if (ch == upd_pkg::CH_PERCENT && !last) begin
                    esc_phase = ESC_PCT;
                    return;
                end
                bytes.insert(bytes.size(), (ch == upd_pkg::CH_PLUS) ? upd_pkg::CH_SPACE : ch);
            end
        endcase
        esc_phase = ESC_NONE;
        for (int i = 0; i < bytes.size(); i++) begin
            decoded_q.insert(decoded_q.size(),
                             '{data: bytes[i],
                               run_last: (i == bytes.size() - 1),
                               text_end: (i == bytes.size() - 1) && last});
        end
    endtask

    task automatic check_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v) begin
            err_cnt++;
            if (err_cnt <= MAX_REPORTS) begin
                $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
            end
        end
    endtask

    // stimulus: directed texts first, then random texts
    initial begin
        int len;
        int r;
        // decoded escapes in both cases, then a plus right after a percent
        // stays a plus and the cut-off escape flushes raw
        put_str("%41%fF%+");
        close_text();
        // percent as first char after percent, then second char not hex
        put_str("%%%4z");
        close_text();
        // plus to space, then text ending on a lone percent
        put_str("+%");
        close_text();
        // escape completed by the final character
        put_str("%a9");
        close_text();
        // decoded zero byte, extreme bytes, and a zero character at text end
        put_str("%00");
        text_buf.insert(text_buf.size(), 8'hFF);
        text_buf.insert(text_buf.size(), 8'h01);
        text_buf.insert(text_buf.size(), 8'h00);
        close_text();
        // text ending on percent and first digit
        put_str("%a");
        close_text();

        // random texts: mostly well-formed escapes, some broken ones and noise;
        // truncation to the drawn length cuts escapes off at text end
        while (char_q.size() < 26 + RANDOM_ITEMS) begin
            len = $urandom_range(1, 12);
            while (text_buf.size() < len) begin
                r = $urandom_range(0, 19);
                if (r < 8) begin
                    text_buf.insert(text_buf.size(), upd_pkg::CH_PERCENT);
                    text_buf.insert(text_buf.size(), rand_hex());
                    text_buf.insert(text_buf.size(), rand_hex());
                end else if (r < 11) begin
                    text_buf.insert(text_buf.size(), upd_pkg::CH_PLUS);
                end else if (r < 16) begin
                    text_buf.insert(text_buf.size(), 8'($urandom_range(1, 255)));
                end else if (r == 16) begin
                    text_buf.insert(text_buf.size(), 8'($urandom_range(0, 255)));
                end else if (r == 17) begin
                    text_buf.insert(text_buf.size(), upd_pkg::CH_PERCENT);
                    text_buf.insert(text_buf.size(), 8'($urandom_range(0, 255)));
                end else if (r == 18) begin
                    text_buf.insert(text_buf.size(), upd_pkg::CH_PERCENT);
                    text_buf.insert(text_buf.size(), rand_hex());
                    text_buf.insert(text_buf.size(), 8'($urandom_range(0, 255)));
                end else begin
                    text_buf.insert(text_buf.size(), upd_pkg::CH_PERCENT);
                    text_buf.insert(text_buf.size(), upd_pkg::CH_PERCENT);
                end
            end
            while (text_buf.size() > len) begin
                void'(text_buf.pop_back());
            end
            close_text();
        end
        n_total = char_q.size();

        // single synchronous reset at the start
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // wait until every character went in and every byte came out
        do begin
            @(negedge i_clk);
        end while (n_taken < n_total || decoded_q.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (err_cnt == 0 && decoded_q.size() == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

    // sender: offers the next character at the falling edge, holds it until taken
    always @(negedge i_clk) begin
        if (in_fire) begin
            cur_busy = 1'b0;
        end
        if (i_rst_n && !cur_busy && char_q.size() > 0 &&
            $urandom_range(0, 99) >= idle_pct(1'b0)) begin
            cur_char = char_q.pop_front();
            cur_busy = 1'b1;
        end
        s_axis_tvalid <= cur_busy;
        s_axis_tdata  <= cur_char.ch;
        s_axis_tlast  <= cur_char.last;
    end

    // receiver: random ready, plus one long hold-off late in the run
    // while the sender keeps offering, so the block's queue fills up
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_axis_tready <= 1'b0;
        end else if (i_rst_n && !hold_done && n_total > 0 && n_taken >= (n_total * 3) / 4) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= idle_pct(1'b1));
        end
    end

    // monitor: samples both handshakes at the rising edge, predicts on input,
    // compares on output, and runs the hang watchdog
    always @(posedge i_clk) begin
        t_dec_byte want;
        in_fire  = i_rst_n && s_axis_tvalid && s_axis_tready;
        out_fire = i_rst_n && m_axis_tvalid && m_axis_tready;
        if (in_fire) begin
            decode_char(s_axis_tdata, s_axis_tlast);
            n_taken++;
        end
        if (out_fire) begin
            if (decoded_q.size() == 0) begin
                err_cnt++;
                if (err_cnt <= MAX_REPORTS) begin
                    $display("%0t: unexpected byte, expected none, actual %h last %b end %b",
                             $time, m_axis_tdata, m_axis_tlast, m_axis_tuser);
                end
            end else begin
                want = decoded_q.pop_front();
                check_field("out_byte", want.data, m_axis_tdata);
                check_field("run_last", want.run_last, m_axis_tlast);
                check_field("text_end", want.text_end, m_axis_tuser);
            end
        end
        if (in_fire || out_fire) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
            $display("tb NOT OK");
            $finish;
        end
    end

endmodule
